// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the LED heartbeat sequencer.
// Define SYNTH to drop every assertion body for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop at every rising clk_i edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cond never holds at a rising clk_i edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hdl/lhb_pkg.sv
// Package for the LED heartbeat sequencer: mode codes, pattern type and
// the pattern tables (step count, duration, level). No dependencies.
package lhb_pkg;

  localparam int ModeW = 3;
  localparam int StepW = 3;
  localparam int DtW   = 12;
  localparam int TimeW = 13;
  localparam int DurW  = 10;

  localparam logic [ModeW-1:0] MODE_ACTIVE  = 3'd1;
  localparam logic [ModeW-1:0] MODE_COMMAND = 3'd2;
  localparam logic [ModeW-1:0] MODE_FAULT   = 3'd3;

  typedef enum logic [1:0] {
    PAT_WAIT,
    PAT_ACTIVE,
    PAT_COMMAND,
    PAT_FAULT
  } pattern_e;

  function automatic pattern_e mode_pattern(logic [ModeW-1:0] mode);
    pattern_e p;
    unique case (mode)
      MODE_ACTIVE:  p = PAT_ACTIVE;
      MODE_COMMAND: p = PAT_COMMAND;
      MODE_FAULT:   p = PAT_FAULT;
      default:      p = PAT_WAIT;
    endcase
    return p;
  endfunction

  // Index of the last step in each pattern.
  function automatic logic [StepW-1:0] last_step(pattern_e p);
    logic [StepW-1:0] l;
    unique case (p)
      PAT_ACTIVE:  l = 3'd5;
      PAT_COMMAND: l = 3'd4;
      default:     l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic [DurW-1:0] step_dur(pattern_e p, logic [StepW-1:0] idx);
    logic [DurW-1:0] d;
    unique case (p)
      PAT_ACTIVE: begin
        unique case (idx)
          3'd1, 3'd3: d = 10'd200;
          3'd4, 3'd5: d = 10'd400;
          default:    d = 10'd100;
        endcase
      end
      PAT_COMMAND: begin
        unique case (idx)
          3'd3, 3'd4: d = 10'd800;
          default:    d = 10'd200;
        endcase
      end
      PAT_FAULT: d = 10'd100;
      default:   d = 10'd500;
    endcase
    return d;
  endfunction

  function automatic logic step_lvl(pattern_e p, logic [StepW-1:0] idx);
    logic l;
    unique case (p)
      PAT_COMMAND: l = ~idx[0] | (idx == 3'd4);
      default:     l = ~idx[0];
    endcase
    return l;
  endfunction

endpackage

// File: hdl/led_heartbeat_pattern_sequencer.sv
// Flow: a tick word is accepted only while idle; the loop then retires its k pattern
// steps (k is at most 41) and loads the result into the output register, or holds it
// there until that register drains. Input reopens once the result is loaded. A single
// subtract/compare unit retires one step per cycle, so the step count sets the rate.
// Reset (async, active low): boot mode, step 0, no accumulated time, LED on,
// output empty.
`include "assert_macros.svh"

module led_heartbeat_pattern_sequencer
  import lhb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ModeW-1:0] system_mode_i,
  input  logic [DtW-1:0]   delta_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             led_on_o,
  output logic [StepW-1:0] step_position_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e           state_q, state_d;
  logic [ModeW-1:0] mode_q, mode_d;
  pattern_e         pat_q, pat_d;
  logic [StepW-1:0] step_q, step_d;
  logic [TimeW-1:0] time_q, time_d;
  logic             led_q, led_d;
  logic             out_valid_q, out_valid_d;
  logic             out_led_q, out_led_d;
  logic [StepW-1:0] out_step_q, out_step_d;

  logic             in_accept;
  logic             out_free;
  pattern_e         pat_in;
  logic             mode_chg;
  logic [TimeW-1:0] base_time;
  logic [TimeW-1:0] cur_dur;
  logic             step_done;
  logic [StepW-1:0] step_nxt;

  // Take a new tick only when the sequencer is idle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  // Output register can take a result this cycle.
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign pat_in    = mode_pattern(system_mode_i);
  assign mode_chg  = (system_mode_i != mode_q);
  assign base_time = mode_chg ? '0 : time_q;

  // The shared unit: compare accumulated time against the current step's
  // duration and subtract it when the step has run out.
  assign cur_dur   = {{(TimeW-DurW){1'b0}}, step_dur(pat_q, step_q)};
  assign step_done = (time_q >= cur_dur);
  assign step_nxt  = (step_q == last_step(pat_q)) ? '0 : step_q + 3'd1;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pat_d       = pat_q;
    step_d      = step_q;
    time_d      = time_q;
    led_d       = led_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_led_d   = out_led_q;
    out_step_d  = out_step_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // Restart the pattern on a mode change, then add the elapsed time.
          mode_d  = system_mode_i;
          pat_d   = pat_in;
          step_d  = mode_chg ? '0 : step_q;
          led_d   = mode_chg ? step_lvl(pat_in, '0) : led_q;
          time_d  = base_time + {{(TimeW-DtW){1'b0}}, delta_ms_i};
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_done) begin
          // Retire one step and drive the next step's level.
          time_d = time_q - cur_dur;
          step_d = step_nxt;
          led_d  = step_lvl(pat_q, step_nxt);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_led_d   = led_q;
          out_step_d  = step_q;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Hold the finished result until the output register drains.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_led_d   = led_q;
          out_step_d  = step_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      pat_q       <= PAT_WAIT;
      step_q      <= '0;
      time_q      <= '0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
      out_led_q   <= 1'b0;
      out_step_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pat_q       <= pat_d;
      step_q      <= step_d;
      time_q      <= time_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
      out_led_q   <= out_led_d;
      out_step_q  <= out_step_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_on_o        = out_led_q;
  assign step_position_o = out_step_q;

  // Between ticks the accumulated time is below the current step's duration.
  `ASSERT_AT(a_idle_time_below_dur, (state_q == ST_IDLE) |-> (time_q < cur_dur), "time left over")
  // The step index never runs past the last step of its pattern.
  `ASSERT_NEVER(a_step_in_range, step_q > last_step(pat_q), "step index beyond pattern")
  // An accepted tick always starts the step loop.
  `ASSERT_AT(a_accept_runs, in_accept |=> (state_q == ST_RUN), "tick not started")
  // A result leaves the loop only into a free output register.
  `ASSERT_AT(a_result_loaded, ((state_q != ST_IDLE) && (state_d == ST_IDLE)) |=> out_valid_q, "result dropped")

endmodule

// File: dv/tb_led_heartbeat_pattern_sequencer.sv
// Self-checking testbench for led_heartbeat_pattern_sequencer: directed ticks, then random ticks,
// each result checked against an in-bench blink pattern predictor.
// Depends on lhb_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_led_heartbeat_pattern_sequencer;
  import lhb_pkg::*;

  localparam int RandTicks     = 400;
  // Longest quiet stretch of a correct run: sender gap, up to 41 steps,
  // receiver stall. Leave a wide margin.
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 64;
  localparam int MaxReports    = 10;

  // One result word: LED level and step index.
  typedef struct packed {
    logic             led;
    logic [StepW-1:0] step;
  } heartbeat_t;

  // One directed row: the tick word, and the result where it is obvious.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DtW-1:0]   dt;
    logic             known;
    heartbeat_t       res;
  } tick_row_t;

  // Blink tables, indexed by pattern_e (wait, active, command, fault).
  localparam int unsigned BLINK_LEN [4]    = '{2, 6, 5, 2};
  localparam int unsigned BLINK_DUR [4][6] = '{
    '{500, 500,   0,   0,   0,   0},
    '{100, 200, 100, 200, 400, 400},
    '{200, 200, 200, 800, 800,   0},
    '{100, 100,   0,   0,   0,   0}
  };
  localparam bit BLINK_LVL [4][6] = '{
    '{1, 0, 0, 0, 0, 0},
    '{1, 0, 1, 0, 1, 0},
    '{1, 0, 1, 0, 1, 0},
    '{1, 0, 0, 0, 0, 0}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [ModeW-1:0] system_mode_i = '0;
  logic [DtW-1:0]   delta_ms_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic             led_on_o;
  logic [StepW-1:0] step_position_o;

  // Predictor state, reset values as after init: boot mode, LED on.
  logic [ModeW-1:0] hb_mode    = '0;
  logic [StepW-1:0] hb_step    = '0;
  logic [TimeW-1:0] hb_elapsed = '0;
  logic             hb_led     = 1'b1;

  heartbeat_t led_expect_q[$];
  int         heartbeat_mismatches = 0;
  int         idle_cycles          = 0;
  int         stall_left           = 0;
  bit         steady_phase         = 1'b0;   // no idling on either side
  tick_row_t  directed_rows[$];

  led_heartbeat_pattern_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .system_mode_i  (system_mode_i),
    .delta_ms_i     (delta_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_on_o       (led_on_o),
    .step_position_o(step_position_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the predictor by one tick word and return the result it should give.
  function automatic heartbeat_t advance_heartbeat(input logic [ModeW-1:0] mode,
                                                   input logic [DtW-1:0] dt);
    pattern_e   pat;
    int         p;
    heartbeat_t res;
    case (mode)
      MODE_ACTIVE:  pat = PAT_ACTIVE;
      MODE_COMMAND: pat = PAT_COMMAND;
      MODE_FAULT:   pat = PAT_FAULT;
      default:      pat = PAT_WAIT;
    endcase
    p = int'(pat);
    // Any change of code restarts, even between two codes that share the wait pattern.
    if (mode != hb_mode) begin
      hb_mode    = mode;
      hb_step    = '0;
      hb_elapsed = '0;
      hb_led     = BLINK_LVL[p][0];
    end
    // Zero elapsed time holds the pattern where it is.
    if (dt != '0) begin
      if (hb_step >= BLINK_LEN[p]) hb_step = '0;
      hb_elapsed = hb_elapsed + dt;
      // Retire every step that the accumulated time covers; wrap after the last.
      while (hb_elapsed >= BLINK_DUR[p][hb_step]) begin
        hb_elapsed = hb_elapsed - TimeW'(BLINK_DUR[p][hb_step]);
        hb_step    = (hb_step + 1 >= BLINK_LEN[p]) ? '0 : hb_step + 1'b1;
        hb_led     = BLINK_LVL[p][hb_step];
      end
    end
    res.led  = hb_led;
    res.step = hb_step;
    return res;
  endfunction

  // Offer one tick word, optionally after an idle burst, and hold it until accepted.
  task automatic send_tick(input logic [ModeW-1:0] mode, input logic [DtW-1:0] dt,
                           input logic known, input heartbeat_t known_res);
    heartbeat_t predicted;
    if (!steady_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    system_mode_i <= mode;
    delta_ms_i    <= dt;
    do @(posedge clk_i); while (in_stall_o);
    // Always advance the predictor so that its state follows the block.
    predicted = advance_heartbeat(mode, dt);
    led_expect_q.push_back(known ? known_res : predicted);
  endtask

  // Drop valid and hold off until every expected result word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: reset, directed table, random ticks, then settle and report.
  initial begin
    tick_row_t        row;
    logic [ModeW-1:0] mode;
    logic [DtW-1:0]   dt;
    int               n;

    // Directed rows. The result is typed in only where it is plain;
    // a zero in the known bit leaves the row to the predictor.
    // First tick after reset in boot mode: no restart, LED stays on.
    directed_rows.push_back('{3'd0, 12'd0,    1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{3'd0, 12'd499,  1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{3'd0, 12'd1,    1'b1, '{1'b0, 3'd1}});
    // Unassigned code after boot: still a change, restart at step 0.
    directed_rows.push_back('{3'd4, 12'd0,    1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{3'd5, 12'd4095, 1'b0, '{1'b0, 3'd0}});
    // Mode change with zero time: restart, no advance.
    directed_rows.push_back('{MODE_ACTIVE,  12'd0,    1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{MODE_ACTIVE,  12'd100,  1'b1, '{1'b0, 3'd1}});
    directed_rows.push_back('{MODE_ACTIVE,  12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_COMMAND, 12'd0,    1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{MODE_COMMAND, 12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_FAULT,   12'd0,    1'b1, '{1'b1, 3'd0}});
    // Longest tick: fault steps are shortest, so many steps retire at once.
    directed_rows.push_back('{MODE_FAULT,   12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_FAULT,   12'd99,   1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_FAULT,   12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{3'd7, 12'd1,    1'b1, '{1'b1, 3'd0}});
    directed_rows.push_back('{3'd6, 12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{3'd6, 12'd0,    1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_ACTIVE,  12'd2048, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_COMMAND, 12'd799,  1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_COMMAND, 12'd1,    1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{3'd0, 12'd4095, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{3'd0, 12'd1365, 1'b0, '{1'b0, 3'd0}});
    directed_rows.push_back('{MODE_COMMAND, 12'd2730, 1'b0, '{1'b0, 3'd0}});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_tick(row.mode, row.dt, row.known, row.res);
    end
    drain_results();

    // Random ticks: modes mostly hold for a run of ticks so patterns
    // get deep, with the elapsed time spread over its whole range.
    mode = ModeW'($urandom_range(0, 7));
    for (n = 0; n < RandTicks; n++) begin
      if (n == RandTicks / 2) drain_results();
      if (n == RandTicks * 5 / 6) steady_phase = 1'b1;
      if ($urandom_range(0, 9) == 0) mode = ModeW'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       dt = '0;
        1:       dt = 12'd4095;
        2, 3:    dt = DtW'($urandom_range(0, 4095));
        4, 5:    dt = DtW'($urandom_range(100, 900));
        default: dt = DtW'($urandom_range(1, 120));
      endcase
      send_tick(mode, dt, 1'b0, '0);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (heartbeat_mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: check each accepted result word, then pick the next stall level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (led_expect_q.size() == 0) begin
        heartbeat_mismatches++;
        if (heartbeat_mismatches <= MaxReports)
          $display("unexpected result word: led=%0b step=%0d", led_on_o, step_position_o);
      end else begin
        if (led_on_o !== led_expect_q[0].led || step_position_o !== led_expect_q[0].step) begin
          heartbeat_mismatches++;
          if (heartbeat_mismatches <= MaxReports)
            $display("result mismatch: expected led=%0b step=%0d, got led=%0b step=%0d",
                     led_expect_q[0].led, led_expect_q[0].step, led_on_o, step_position_o);
        end
        void'(led_expect_q.pop_front());
      end
    end
    // Stall in bursts of random length; none in the steady phase.
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!steady_phase && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
